/* hw/rtl/fpa_pkg.sv */
package fpa_pkg;

  localparam int FracBits   = 8;
  localparam int WordBits   = 32;
  localparam int DataW      = 32;
  localparam int SatBits    = (WordBits > DataW) ? DataW : WordBits;
  localparam int ExtW       = 2 * DataW;
  localparam int NumW       = DataW + FracBits;
  localparam int StepInc    = 1;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic signed [ExtW-1:0] SatHi =
    {{(ExtW - SatBits + 1){1'b0}}, {(SatBits - 1){1'b1}}};
  localparam logic signed [ExtW-1:0] SatLo = ~SatHi;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdGt      = 4'd4,
    CmdLt      = 4'd5,
    CmdGe      = 4'd6,
    CmdLe      = 4'd7,
    CmdEq      = 4'd8,
    CmdNe      = 4'd9,
    CmdMin     = 4'd10,
    CmdMax     = 4'd11,
    CmdInc     = 4'd12,
    CmdDec     = 4'd13,
    CmdToInt   = 4'd14,
    CmdFromInt = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KindDone = 2'd0,
    KindMul  = 2'd1,
    KindDiv  = 2'd2
  } kind_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    compare_true;
    status_e                 status;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    kind_e                   kind;
    logic                    neg;
    logic signed [DataW-1:0] value;
    logic                    cmp;
    status_e                 status;
    logic [DataW-1:0]        mag_a;
    logic [DataW-1:0]        mag_b;
  } job_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    neg;
    logic signed [DataW-1:0] value;
    logic                    cmp;
    status_e                 status;
    logic [DataW-1:0]        den;
    logic [DataW-1:0]        rem;
    logic [NumW-1:0]         nq;
    logic [ExtW-1:0]         prod;
  } stage_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    status_e                 status;
  } sat_t;

  function automatic sat_t sat_clamp(logic signed [ExtW-1:0] v);
    sat_t r;
    r.value  = v[DataW-1:0];
    r.status = StOk;
    if (v > SatHi) begin
      r.value  = SatHi[DataW-1:0];
      r.status = StOverflow;
    end else if (v < SatLo) begin
      r.value  = SatLo[DataW-1:0];
      r.status = StOverflow;
    end
    return r;
  endfunction

  function automatic logic signed [ExtW-1:0] signed_of(logic [ExtW-1:0] mag, logic neg);
    logic signed [ExtW-1:0] m;
    m = $signed(mag);
    return neg ? -m : m;
  endfunction

endpackage

/* hw/rtl/fpa_queue.sv */
module fpa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpa_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fpa_pkg::job_t head_o
);

  fpa_pkg::job_t                      mem_q [fpa_pkg::QueueDepth];
  logic [fpa_pkg::QueuePtrW-1:0]      wptr_q, wptr_d;
  logic [fpa_pkg::QueuePtrW-1:0]      rptr_q, rptr_d;
  logic [fpa_pkg::QueueCntW-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == fpa_pkg::QueueCntW'(fpa_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == fpa_pkg::QueuePtrW'(fpa_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == fpa_pkg::QueuePtrW'(fpa_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fpa_pkg::QueueCntW'(fpa_pkg::QueueDepth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

/* hw/rtl/fpa_front.sv */
module fpa_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::req_t in_req_i,
  input  logic          full_i,
  output logic          push_o,
  output fpa_pkg::job_t job_o
);

  logic signed [fpa_pkg::DataW-1:0] a, b;
  logic signed [fpa_pkg::ExtW-1:0]  a_ext, b_ext;
  logic [fpa_pkg::DataW-1:0]        mag_a, mag_b;
  fpa_pkg::sat_t                    sat;
  logic                             use_sat;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign a     = in_req_i.operand_a;
  assign b     = in_req_i.operand_b;
  assign a_ext = {{(fpa_pkg::ExtW - fpa_pkg::DataW){a[fpa_pkg::DataW-1]}}, a};
  assign b_ext = {{(fpa_pkg::ExtW - fpa_pkg::DataW){b[fpa_pkg::DataW-1]}}, b};
  assign mag_a = a[fpa_pkg::DataW-1] ? fpa_pkg::DataW'(-a) : a;
  assign mag_b = b[fpa_pkg::DataW-1] ? fpa_pkg::DataW'(-b) : b;

  always_comb begin
    sat     = fpa_pkg::sat_clamp(a_ext + b_ext);
    use_sat = 1'b1;
    job_o.kind   = fpa_pkg::KindDone;
    job_o.neg    = a[fpa_pkg::DataW-1] ^ b[fpa_pkg::DataW-1];
    job_o.value  = '0;
    job_o.cmp    = 1'b0;
    job_o.status = fpa_pkg::StOk;
    job_o.mag_a  = mag_a;
    job_o.mag_b  = mag_b;
    case (in_req_i.command)
      fpa_pkg::CmdAdd: sat = fpa_pkg::sat_clamp(a_ext + b_ext);
      fpa_pkg::CmdSub: sat = fpa_pkg::sat_clamp(a_ext - b_ext);
      fpa_pkg::CmdMul: begin
        use_sat    = 1'b0;
        job_o.kind = fpa_pkg::KindMul;
      end
      fpa_pkg::CmdDiv: begin
        use_sat = 1'b0;
        if (b == '0) begin
          job_o.status = fpa_pkg::StDivZero;
        end else begin
          job_o.kind = fpa_pkg::KindDiv;
        end
      end
      fpa_pkg::CmdGt: begin use_sat = 1'b0; job_o.cmp = (a > b);  end
      fpa_pkg::CmdLt: begin use_sat = 1'b0; job_o.cmp = (a < b);  end
      fpa_pkg::CmdGe: begin use_sat = 1'b0; job_o.cmp = (a >= b); end
      fpa_pkg::CmdLe: begin use_sat = 1'b0; job_o.cmp = (a <= b); end
      fpa_pkg::CmdEq: begin use_sat = 1'b0; job_o.cmp = (a == b); end
      fpa_pkg::CmdNe: begin use_sat = 1'b0; job_o.cmp = (a != b); end
      fpa_pkg::CmdMin: sat = fpa_pkg::sat_clamp((a < b) ? a_ext : b_ext);
      fpa_pkg::CmdMax: sat = fpa_pkg::sat_clamp((a > b) ? a_ext : b_ext);
      fpa_pkg::CmdInc: sat = fpa_pkg::sat_clamp(a_ext + fpa_pkg::ExtW'(fpa_pkg::StepInc));
      fpa_pkg::CmdDec: sat = fpa_pkg::sat_clamp(a_ext - fpa_pkg::ExtW'(fpa_pkg::StepInc));
      fpa_pkg::CmdToInt: sat = fpa_pkg::sat_clamp(fpa_pkg::signed_of(
        fpa_pkg::ExtW'(mag_a >> fpa_pkg::FracBits), a[fpa_pkg::DataW-1]));
      fpa_pkg::CmdFromInt: sat = fpa_pkg::sat_clamp(a_ext <<< fpa_pkg::FracBits);
      default: use_sat = 1'b0;
    endcase
    if (use_sat) begin
      job_o.value  = sat.value;
      job_o.status = sat.status;
    end
  end

endmodule

/* hw/rtl/fpa_back.sv */
module fpa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  fpa_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::rsp_t out_rsp_o
);

  localparam int Last = fpa_pkg::NumW - 1;

  fpa_pkg::stage_t stage_q [fpa_pkg::NumW];
  fpa_pkg::stage_t stage_d [fpa_pkg::NumW];
  logic [fpa_pkg::NumW-1:0] vld_q;
  logic            adv;
  logic            out_vld_q;
  fpa_pkg::rsp_t   rsp_q, rsp_d;
  fpa_pkg::stage_t entry;
  fpa_pkg::sat_t   mul_sat, div_sat;
  logic [fpa_pkg::ExtW-1:0] mul_mag, div_mag;
  logic            rnd;

  // One restoring-division bit per stage.
  function automatic fpa_pkg::stage_t div_step(fpa_pkg::stage_t s);
    fpa_pkg::stage_t r;
    logic [fpa_pkg::DataW:0] trial;
    logic                    qbit;
    r     = s;
    trial = {s.rem, s.nq[fpa_pkg::NumW-1]};
    qbit  = (trial >= {1'b0, s.den});
    if (qbit) begin
      trial = trial - {1'b0, s.den};
    end
    r.rem = trial[fpa_pkg::DataW-1:0];
    r.nq  = {s.nq[fpa_pkg::NumW-2:0], qbit};
    return r;
  endfunction

  assign adv         = !out_vld_q || out_ready_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    entry.kind   = head_i.kind;
    entry.neg    = head_i.neg;
    entry.value  = head_i.value;
    entry.cmp    = head_i.cmp;
    entry.status = head_i.status;
    entry.den    = head_i.mag_b;
    entry.rem    = '0;
    entry.nq     = {head_i.mag_a, {fpa_pkg::FracBits{1'b0}}};
    entry.prod   = fpa_pkg::ExtW'(head_i.mag_a) * fpa_pkg::ExtW'(head_i.mag_b);

    // round the registered product half away from zero
    mul_mag = (stage_q[0].prod + fpa_pkg::ExtW'(1 << (fpa_pkg::FracBits - 1)))
              >> fpa_pkg::FracBits;
    mul_sat = fpa_pkg::sat_clamp(fpa_pkg::signed_of(mul_mag, stage_q[0].neg));

    stage_d[0] = div_step(entry);
    for (int s = 1; s < fpa_pkg::NumW; s++) begin
      stage_d[s] = div_step(stage_q[s-1]);
    end
    if (stage_q[0].kind == fpa_pkg::KindMul) begin
      stage_d[1].value  = mul_sat.value;
      stage_d[1].status = mul_sat.status;
    end

    rnd     = ({stage_q[Last].rem, 1'b0} >= {1'b0, stage_q[Last].den});
    div_mag = fpa_pkg::ExtW'(stage_q[Last].nq) + fpa_pkg::ExtW'(rnd);
    div_sat = fpa_pkg::sat_clamp(fpa_pkg::signed_of(div_mag, stage_q[Last].neg));

    rsp_d.value        = stage_q[Last].value;
    rsp_d.compare_true = stage_q[Last].cmp;
    rsp_d.status       = stage_q[Last].status;
    if (stage_q[Last].kind == fpa_pkg::KindDiv) begin
      rsp_d.value  = div_sat.value;
      rsp_d.status = div_sat.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[fpa_pkg::NumW-2:0], pop_o};
      out_vld_q <= vld_q[Last];
    end
  end

  // hold all stages while the output register waits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < fpa_pkg::NumW; s++) begin
        stage_q[s] <= stage_d[s];
      end
      rsp_q <= rsp_d;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_divzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (rsp_q.status == fpa_pkg::StDivZero) |-> (rsp_q.value == '0))
    else $error("divide by zero with nonzero value");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rsp_q.compare_true |-> (rsp_q.value == '0) &&
      (rsp_q.status == fpa_pkg::StOk))
    else $error("compare result carries value or status");

endmodule

/* hw/rtl/fixed_point_q24_8_alu.sv */
// Signed Q24.8 fixed-point ALU.
// Input channel: in_valid_i / in_ready_o with in_req_i (command, operand_a,
// operand_b). Output channel: out_valid_o / out_ready_i with out_rsp_o
// (value, compare_true, status). Every request yields exactly one response,
// in request order.
// The front decodes the command and finishes add, sub, compares, min, max,
// inc, dec and the integer conversions at once; a two-entry queue hands the
// request to a 40-stage back pipeline that forms the product in its first
// stage and the quotient one bit per stage (restoring division over the
// 40-bit scaled numerator). All commands take the same path.
// Throughput: one request per cycle while the output is not stalled.
// When out_valid_o is high and out_ready_i is low, the output register and
// the whole back pipeline hold; the queue fills to its two entries, then in_ready_o drops.
// Reset empties the queue and the pipeline; no response is pending after it.
module fixed_point_q24_8_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::rsp_t out_rsp_o
);

  fpa_pkg::job_t job, head;
  logic          push, pop, full, empty;

  fpa_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job)
  );

  fpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  fpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* tb/tb_fixed_point_q24_8_alu.sv */
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;

  localparam int RandItems = 1100;
  localparam int Latency   = 41;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  fpa_pkg::req_t  in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  fpa_pkg::rsp_t  out_rsp_o;

  fixed_point_q24_8_alu i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  typedef struct {
    fpa_pkg::req_t req;
    logic          typed;
    fpa_pkg::rsp_t rsp;
  } vector_t;

  fpa_pkg::rsp_t pending_rsp[$];
  int   error_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb_fixed_point_q24_8_alu failed");
    $finish;
  end

  function automatic fpa_pkg::rsp_t mk_rsp(logic [31:0] v, logic c, fpa_pkg::status_e s);
    fpa_pkg::rsp_t r;
    r.value        = v;
    r.compare_true = c;
    r.status       = s;
    return r;
  endfunction

  function automatic fpa_pkg::rsp_t saturate(logic signed [65:0] v);
    fpa_pkg::rsp_t r;
    r = mk_rsp(v[31:0], 1'b0, fpa_pkg::StOk);
    if (v > 66'sd2147483647) r = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow);
    else if (v < -66'sd2147483648) r = mk_rsp(32'h80000000, 1'b0, fpa_pkg::StOverflow);
    return r;
  endfunction

  function automatic fpa_pkg::rsp_t alu_result(fpa_pkg::req_t q);
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic [65:0] ma;
    logic [65:0] mb;
    logic [65:0] mag;
    logic        neg;
    logic signed [65:0] sv;
    fpa_pkg::rsp_t r;
    a   = 66'(q.operand_a);
    b   = 66'(q.operand_b);
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    r   = mk_rsp(32'd0, 1'b0, fpa_pkg::StOk);
    case (q.command)
      fpa_pkg::CmdAdd: r = saturate(a + b);
      fpa_pkg::CmdSub: r = saturate(a - b);
      fpa_pkg::CmdMul: begin
        mag = (ma * mb + 66'd128) >> 8;
        sv  = neg ? -$signed(mag) : $signed(mag);
        r   = saturate(sv);
      end
      fpa_pkg::CmdDiv: begin
        if (b == 0) begin
          r = mk_rsp(32'd0, 1'b0, fpa_pkg::StDivZero);
        end else begin
          mag = ((ma << 8) * 2 + mb) / (mb * 2);
          sv  = neg ? -$signed(mag) : $signed(mag);
          r   = saturate(sv);
        end
      end
      fpa_pkg::CmdGt:  r.compare_true = a > b;
      fpa_pkg::CmdLt:  r.compare_true = a < b;
      fpa_pkg::CmdGe:  r.compare_true = a >= b;
      fpa_pkg::CmdLe:  r.compare_true = a <= b;
      fpa_pkg::CmdEq:  r.compare_true = a == b;
      fpa_pkg::CmdNe:  r.compare_true = a != b;
      fpa_pkg::CmdMin: r = saturate(a < b ? a : b);
      fpa_pkg::CmdMax: r = saturate(a > b ? a : b);
      fpa_pkg::CmdInc: r = saturate(a + 1);
      fpa_pkg::CmdDec: r = saturate(a - 1);
      fpa_pkg::CmdToInt: begin
        mag = ma >> 8;
        r   = saturate(a < 0 ? -$signed(mag) : $signed(mag));
      end
      default: r = saturate(a * 256);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Pick random operands with a bias toward edges and small magnitudes.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 1023) - 512;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(fpa_pkg::req_t q);
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(alu_result(q));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at random, check each accepted response.
  always @(posedge clk_i) begin
    fpa_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response", out_rsp_o.value, 32'd0);
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp_o.value !== want.value)
            report_mismatch("value", out_rsp_o.value, want.value);
          if (out_rsp_o.compare_true !== want.compare_true)
            report_mismatch("compare_true", 32'(out_rsp_o.compare_true),
                            32'(want.compare_true));
          if (out_rsp_o.status !== want.status)
            report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    vector_t       table_q[$];
    vector_t       v;
    fpa_pkg::req_t q;
    int            phase;
    int            n;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: typed expectations for extremes and errors.
    v.typed = 1'b1;
    v.req = '{fpa_pkg::CmdAdd, 32'h7fffffff, 32'h1};
    v.rsp = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdSub, 32'h80000000, 32'h1};
    v.rsp = mk_rsp(32'h80000000, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDiv, 32'h100, 32'h0};
    v.rsp = mk_rsp(32'h0, 1'b0, fpa_pkg::StDivZero); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDiv, 32'h80000000, 32'h0};
    v.rsp = mk_rsp(32'h0, 1'b0, fpa_pkg::StDivZero); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdMul, 32'h7fffffff, 32'h7fffffff};
    v.rsp = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdMul, 32'h80000000, 32'h80000000};
    v.rsp = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdInc, 32'h7fffffff, 32'hffffffff};
    v.rsp = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDec, 32'h80000000, 32'h0};
    v.rsp = mk_rsp(32'h80000000, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdFromInt, 32'h00800000, 32'h0};
    v.rsp = mk_rsp(32'h7fffffff, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdFromInt, 32'hff7fffff, 32'h0};
    v.rsp = mk_rsp(32'h80000000, 1'b0, fpa_pkg::StOverflow); table_q.push_back(v);
    v.req = '{fpa_pkg::CmdEq, 32'h5, 32'h5};
    v.rsp = mk_rsp(32'h0, 1'b1, fpa_pkg::StOk); table_q.push_back(v);
    // Remaining rows go through the predictor.
    v.typed = 1'b0;
    v.req = '{fpa_pkg::CmdMul, 32'h00000180, 32'hfffffe80}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdMul, 32'h00000001, 32'h00000080}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDiv, 32'h00000100, 32'h00000300}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDiv, 32'h80000000, 32'h00000001}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdDiv, 32'hffffff00, 32'h00000200}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdGt, 32'h80000000, 32'h7fffffff}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdLt, 32'h80000000, 32'h7fffffff}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdGe, 32'h3, 32'h3}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdLe, 32'h4, 32'h3}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdNe, 32'hffffffff, 32'hffffffff}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdMin, 32'h7, 32'h7}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdMax, 32'h80000000, 32'h7fffffff}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdToInt, 32'hfffffe80, 32'h12345678}; table_q.push_back(v);
    v.req = '{fpa_pkg::CmdToInt, 32'h80000000, 32'h0}; table_q.push_back(v);

    foreach (table_q[i]) begin
      if (table_q[i].typed && alu_result(table_q[i].req) !== table_q[i].rsp)
        report_mismatch("directed row", i, 0);
      send(table_q[i].req);
    end
    drain();

    // Idling phases: none, sender, receiver, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 38 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 38 : 0;
      for (n = 0; n < RandItems / 4; n++) begin
        q.command   = fpa_pkg::cmd_e'($urandom_range(0, 15));
        q.operand_a = rand_operand();
        q.operand_b = rand_operand();
        send(q);
      end
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_fixed_point_q24_8_alu passed");
    end else begin
      $display("tb_fixed_point_q24_8_alu failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_q24_8_alu.sv
tb/tb_fixed_point_q24_8_alu.sv
